// ===== rtl/abst_pkg.sv =====
// Package for the array binary search tree: node pool sizes, index and key types,
// command and status codes, and the result of the shared compare/step unit.
// No dependencies.
package abst_pkg;

  localparam int NODES      = 1024;
  localparam int ADDR_W     = $clog2(NODES);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int IN_DATA_W  = 72;   // cmd + key + value = 66 bits, padded to bytes
  localparam int OUT_DATA_W = 48;   // status + value + count = 45 bits, padded to bytes

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [VAL_W-1:0]  val_t;

  // null link marker: one past the last node
  localparam idx_t NIL = IDX_W'(NODES);

  // commands
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_SEARCH = 3'd1;
  localparam logic [2:0] CMD_MIN    = 3'd2;
  localparam logic [2:0] CMD_MAX    = 3'd3;
  localparam logic [2:0] CMD_SUCC   = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // output of the compare/step unit
  typedef struct packed {
    logic eq;   // search key equals node key
    logic lt;   // search key below node key
    idx_t nxt;  // link to follow from this node
  } step_res_t;

  function automatic logic is_nil(input idx_t i);
    return (i == NIL);
  endfunction

endpackage

// ===== rtl/array_binary_search_tree.sv =====
// Top level of the array binary search tree: command sequencer, node pool RAMs
// and output register. Depends on abst_pkg, abst_ram and abst_step.
//
//  channel | dir | fields (lowest bit first)
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | cmd[2:0], key[33:3], value[65:34]            (72 bits)
//  m_*     | out | status[1:0], result_value[33:2], node_count[44:34] (48 bits)
//
// Each node visited passes through S_READ (address into the node RAMs), then
// S_EVAL (the compare/step on the registered read data). An insert that
// allocates also passes through S_ALLOC before S_FIN registers the result.
// Reset (rst, synchronous) empties the tree; the node RAMs are not cleared.
// One command at a time: s_tready is high only while idle. A finished result
// waits in the output register; the next command is accepted meanwhile, but
// its own result holds in S_FIN until the earlier one has been taken.
module array_binary_search_tree (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [abst_pkg::IN_DATA_W-1:0]  s_tdata,  // cmd, key, value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [abst_pkg::OUT_DATA_W-1:0] m_tdata   // status, result_value, node_count
);
  import abst_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_ALLOC, S_FIN} state_t;
  typedef enum logic [1:0] {PH_FIND, PH_EXT, PH_UP} phase_t;

  state_t     state;
  phase_t     phase;
  logic [2:0] cmd_q;
  key_t       key_q;
  val_t       val_q;
  idx_t       cur;
  idx_t       child;
  idx_t       par;
  idx_t       root;
  idx_t       count;
  logic       go_left;
  logic [1:0] res_status;
  val_t       res_value;

  logic [2:0] in_cmd;
  key_t       in_key;
  val_t       in_val;

  key_t rd_key;
  val_t rd_val;
  idx_t rd_left;
  idx_t rd_right;
  idx_t rd_par;

  step_res_t step;

  logic  alloc;
  logic  link_we;
  logic  val_we;
  addr_t val_waddr;
  val_t  val_wdata;
  logic  left_we;
  logic  right_we;
  addr_t link_waddr;
  idx_t  link_wdata;

  assign in_cmd = s_tdata[2:0];
  assign in_key = s_tdata[KEY_W+2:3];
  assign in_val = s_tdata[VAL_W+KEY_W+2:KEY_W+3];

  assign s_tready = (state == S_IDLE);

  // shared compare/step unit
  abst_step u_step (
    .use_key  (phase == PH_FIND),
    .go_left  (go_left),
    .key      (key_q),
    .node_key (rd_key),
    .left     (rd_left),
    .right    (rd_right),
    .res      (step)
  );

  // node pool write control
  always_comb begin
    alloc   = (state == S_ALLOC);
    link_we = (state == S_EVAL) && (phase == PH_FIND) && (cmd_q == CMD_INSERT) &&
              !step.eq && is_nil(step.nxt) && !count[IDX_W-1];
    val_we    = alloc ||
                ((state == S_EVAL) && (phase == PH_FIND) && (cmd_q == CMD_INSERT) && step.eq);
    val_waddr = alloc ? count[ADDR_W-1:0] : cur[ADDR_W-1:0];
    val_wdata = val_q;
    left_we   = alloc || (link_we && step.lt);
    right_we  = alloc || (link_we && !step.lt);
    link_waddr = alloc ? count[ADDR_W-1:0] : cur[ADDR_W-1:0];
    link_wdata = alloc ? NIL : count;
  end

  abst_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
    .clk(clk), .we(alloc), .waddr(count[ADDR_W-1:0]), .wdata(key_q),
    .raddr(cur[ADDR_W-1:0]), .rdata(rd_key)
  );

  abst_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(cur[ADDR_W-1:0]), .rdata(rd_val)
  );

  abst_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_left_ram (
    .clk(clk), .we(left_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur[ADDR_W-1:0]), .rdata(rd_left)
  );

  abst_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_right_ram (
    .clk(clk), .we(right_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur[ADDR_W-1:0]), .rdata(rd_right)
  );

  abst_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_par_ram (
    .clk(clk), .we(alloc), .waddr(count[ADDR_W-1:0]), .wdata(par),
    .raddr(cur[ADDR_W-1:0]), .rdata(rd_par)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_FIND;
      root     <= NIL;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // taken result drops out unless S_FIN reloads the register this cycle
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q      <= in_cmd;
            key_q      <= in_key;
            val_q      <= in_val;
            res_status <= STAT_OK;
            res_value  <= '0;
            cur        <= root;
            phase      <= PH_FIND;
            go_left    <= (in_cmd == CMD_MIN);
            if (in_cmd > CMD_SUCC) begin
              state <= S_FIN;
            end else if (is_nil(root)) begin
              if (in_cmd == CMD_INSERT) begin
                par   <= NIL;
                state <= S_ALLOC;
              end else begin
                res_status <= STAT_EMPTY;
                state      <= S_FIN;
              end
            end else begin
              if (in_cmd == CMD_MIN || in_cmd == CMD_MAX) begin
                phase <= PH_EXT;
              end
              state <= S_READ;
            end
          end
        end

        S_READ: begin
          state <= S_EVAL;
        end

        S_EVAL: begin
          case (phase)
            // descend by key
            PH_FIND: begin
              if (step.eq) begin
                case (cmd_q)
                  CMD_INSERT: state <= S_FIN;
                  CMD_SEARCH: begin
                    res_value <= rd_val;
                    state     <= S_FIN;
                  end
                  default: begin
                    if (!is_nil(rd_right)) begin
                      cur     <= rd_right;
                      phase   <= PH_EXT;
                      go_left <= 1'b1;
                      state   <= S_READ;
                    end else if (is_nil(rd_par)) begin
                      res_status <= STAT_MISS;
                      state      <= S_FIN;
                    end else begin
                      child <= cur;
                      cur   <= rd_par;
                      phase <= PH_UP;
                      state <= S_READ;
                    end
                  end
                endcase
              end else if (!is_nil(step.nxt)) begin
                cur   <= step.nxt;
                state <= S_READ;
              end else if (cmd_q == CMD_INSERT) begin
                if (count[IDX_W-1]) begin
                  res_status <= STAT_FULL;
                  state      <= S_FIN;
                end else begin
                  par   <= cur;
                  state <= S_ALLOC;
                end
              end else begin
                res_status <= STAT_MISS;
                state      <= S_FIN;
              end
            end

            // run to the end of one side
            PH_EXT: begin
              if (!is_nil(step.nxt)) begin
                cur   <= step.nxt;
                state <= S_READ;
              end else begin
                res_value <= rd_val;
                state     <= S_FIN;
              end
            end

            // climb while we came up from a right child
            PH_UP: begin
              if (rd_right == child) begin
                if (is_nil(rd_par)) begin
                  res_status <= STAT_MISS;
                  state      <= S_FIN;
                end else begin
                  child <= cur;
                  cur   <= rd_par;
                  state <= S_READ;
                end
              end else begin
                res_value <= rd_val;
                state     <= S_FIN;
              end
            end

            default: begin
              state <= S_FIN;
            end
          endcase
        end

        // new node goes in at the next free slot
        S_ALLOC: begin
          if (is_nil(root)) begin
            root <= count;
          end
          count <= count + 1'b1;
          state <= S_FIN;
        end

        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {(OUT_DATA_W-IDX_W-VAL_W-2)'(0), count, res_value, res_status};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NIL)
    else $error("node count beyond pool size");

  a_empty_root: assert property (@(posedge clk) disable iff (rst)
    is_nil(root) == (count == '0))
    else $error("root and node count disagree");

  a_count_alloc: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (count != $past(count)) |-> $past(state) == S_ALLOC)
    else $error("node count moved outside allocation");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_walk_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !is_nil(cur))
    else $error("walk reads through a null link");

endmodule

// ===== rtl/abst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/abst_step.sv =====
// Shared compare/step unit: compares the search key with a node key and picks
// the link to follow next. Depends on abst_pkg.
module abst_step (
  input  logic               use_key,   // descend by key compare
  input  logic               go_left,   // otherwise follow this side
  input  abst_pkg::key_t     key,
  input  abst_pkg::key_t     node_key,
  input  abst_pkg::idx_t     left,
  input  abst_pkg::idx_t     right,
  output abst_pkg::step_res_t res
);
  import abst_pkg::*;

  logic take_left;

  always_comb begin
    take_left = use_key ? (key < node_key) : go_left;
    res.eq    = (key == node_key);
    res.lt    = (key < node_key);
    res.nxt   = take_left ? left : right;
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for array_binary_search_tree: drives command transactions
// and checks every result against a shadow copy of the node pool.
// Depends on abst_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import abst_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 426;

  // spare command codes: the block must leave the tree alone
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam key_t KEY_TOP = '1;

  typedef struct packed {
    logic [1:0]       status;
    val_t             value;
    logic [IDX_W-1:0] count;
  } tree_result_t;

  // Shadow node pool: updated on each accepted command, queues its result
  class node_pool_tracker;
    key_t         node_key   [NODES];
    val_t         node_val   [NODES];
    idx_t         left_link  [NODES];
    idx_t         right_link [NODES];
    idx_t         up_link    [NODES];
    idx_t         root;
    int unsigned  used;
    int unsigned  errors;
    tree_result_t due_results[$];

    function new();
      root   = NIL;
      used   = 0;
      errors = 0;
    endfunction

    // node holding k, or NIL
    function idx_t locate(key_t k);
      idx_t x;
      int   steps;
      x     = root;
      steps = 0;
      while (x < NODES && steps < NODES) begin
        if (node_key[x] == k) return x;
        x = (k < node_key[x]) ? left_link[x] : right_link[x];
        steps++;
      end
      return NIL;
    endfunction

    // follow left (or right) links from x as far as they go
    function idx_t slide(idx_t x, bit go_left);
      idx_t n;
      for (int steps = 0; steps < NODES; steps++) begin
        n = go_left ? left_link[x] : right_link[x];
        if (n >= NODES) break;
        x = n;
      end
      return x;
    endfunction

    function void note_command(logic [2:0] cmd, key_t k, val_t v);
      tree_result_t r;
      idx_t         x, y, s, c;
      int           steps;
      bit           hit;
      r.status = STAT_OK;
      r.value  = '0;
      case (cmd)
        CMD_INSERT: begin
          x     = root;
          y     = NIL;
          hit   = 1'b0;
          steps = 0;
          while (x < NODES && steps < NODES) begin
            y = x;
            if (node_key[x] == k) begin
              node_val[x] = v;
              hit         = 1'b1;
              break;
            end
            x = (k < node_key[x]) ? left_link[x] : right_link[x];
            steps++;
          end
          if (!hit) begin
            if (used >= NODES) begin
              r.status = STAT_FULL;
            end else begin
              node_key[used]   = k;
              node_val[used]   = v;
              left_link[used]  = NIL;
              right_link[used] = NIL;
              up_link[used]    = y;
              if (y >= NODES) root = idx_t'(used);
              else if (k < node_key[y]) left_link[y] = idx_t'(used);
              else right_link[y] = idx_t'(used);
              used++;
            end
          end
        end
        CMD_SEARCH, CMD_MIN, CMD_MAX, CMD_SUCC: begin
          if (root >= NODES) begin
            r.status = STAT_EMPTY;
          end else if (cmd == CMD_SEARCH) begin
            x = locate(k);
            if (x < NODES) r.value = node_val[x];
            else r.status = STAT_MISS;
          end else if (cmd != CMD_SUCC) begin
            r.value = node_val[slide(root, cmd == CMD_MIN)];
          end else begin
            x = locate(k);
            s = NIL;
            if (x < NODES) begin
              if (right_link[x] < NODES) begin
                s = slide(right_link[x], 1'b1);
              end else begin
                // climb while we come up from a right child
                c     = x;
                s     = up_link[x];
                steps = 0;
                while (s < NODES && right_link[s] == c && steps < NODES) begin
                  c = s;
                  s = up_link[s];
                  steps++;
                end
              end
            end
            if (s < NODES) r.value = node_val[s];
            else r.status = STAT_MISS;
          end
        end
        default: ;
      endcase
      r.count = IDX_W'(used);
      due_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      tree_result_t want, got;
      got.status = d[1:0];
      got.value  = d[33:2];
      got.count  = d[44:34];
      if (due_results.size() == 0) begin
        $error("result transaction with nothing outstanding: status %0d value %h count %0d",
               got.status, got.value, got.count);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("result_value: expected %h, actual %h", want.value, got.value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("node_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  node_pool_tracker tracker;
  key_t             known_keys[$];
  bit               calm   = 1'b0;
  int               cycles = 0;

  array_binary_search_tree u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // keys: biased towards ones already in the tree so hits and successors happen
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && known_keys.size() > 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (r < 60) return key_t'($urandom_range(0, 63));
    if (r < 64) return r[0] ? KEY_TOP : '0;
    return key_t'($urandom());
  endfunction

  // one command transaction; valid stays high when the next follows at once
  task automatic send_cmd(input logic [2:0] cmd, input key_t k, input val_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({v, k, cmd});
    do @(posedge clk); while (!s_tready);
    tracker.note_command(cmd, k, v);
    if (cmd == CMD_INSERT) known_keys.push_back(k);
  endtask

  task automatic send_random();
    int         r;
    logic [2:0] cmd;
    val_t       v;
    r = $urandom_range(0, 99);
    if (r < 35) cmd = CMD_INSERT;
    else if (r < 60) cmd = CMD_SEARCH;
    else if (r < 68) cmd = CMD_MIN;
    else if (r < 76) cmd = CMD_MAX;
    else if (r < 95) cmd = CMD_SUCC;
    else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_RSVD5;
        1:       cmd = CMD_RSVD6;
        default: cmd = CMD_RSVD7;
      endcase
    end
    r = $urandom_range(0, 9);
    v = (r == 0) ? '0 : (r == 1) ? '1 : val_t'($urandom());
    send_cmd(cmd, pick_key(), v);
  endtask

  // result side: check each transaction, stall at random
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty tree
    send_cmd(CMD_SEARCH, 31'd5, '0);
    send_cmd(CMD_MIN, '0, '0);
    send_cmd(CMD_MAX, '0, '0);
    send_cmd(CMD_SUCC, 31'd5, '0);

    // small tree with key and value extremes, then an overwrite
    send_cmd(CMD_INSERT, 31'd1000, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, '0, '0);
    send_cmd(CMD_INSERT, KEY_TOP, 32'h1234_5678);
    send_cmd(CMD_INSERT, 31'd500, 32'hA5A5_A5A5);
    send_cmd(CMD_INSERT, 31'd1500, 32'h5A5A_5A5A);
    send_cmd(CMD_INSERT, 31'd250, 32'd1);
    send_cmd(CMD_INSERT, 31'd750, 32'd2);
    send_cmd(CMD_INSERT, 31'd1000, 32'hDEAD_BEEF);

    // lookups: hit, miss, extremes
    send_cmd(CMD_SEARCH, 31'd1000, '0);
    send_cmd(CMD_SEARCH, 31'd7, '0);
    send_cmd(CMD_SEARCH, KEY_TOP, '0);
    send_cmd(CMD_MIN, '0, '0);
    send_cmd(CMD_MAX, '0, '0);

    // successor via right subtree, via ancestors, of the maximum, of an absent key
    send_cmd(CMD_SUCC, 31'd1000, '0);
    send_cmd(CMD_SUCC, 31'd750, '0);
    send_cmd(CMD_SUCC, KEY_TOP, '0);
    send_cmd(CMD_SUCC, 31'd600, '0);
    send_cmd(CMD_SUCC, '0, '0);

    // spare codes
    send_cmd(CMD_RSVD5, KEY_TOP, '1);
    send_cmd(CMD_RSVD6, 31'd1000, 32'h0000_FFFF);
    send_cmd(CMD_RSVD7, '0, 32'hFFFF_0000);

    // random mix, with calm stretches now and then
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      send_random();
    end
    s_tvalid <= 1'b0;

    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.due_results.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
